@@ rtl/i2cmbe_pkg.sv @@
// Shared constants and types for the I2C master bit engine.
package i2cmbe_pkg;

   typedef logic [2:0]  cmd_type;
   typedef logic [7:0]  byte_type;
   typedef logic [15:0] ticks_type;

   localparam cmd_type CMD_NONE  = 3'd0;
   localparam cmd_type CMD_START = 3'd1;
   localparam cmd_type CMD_STOP  = 3'd2;
   localparam cmd_type CMD_WRITE = 3'd3;
   localparam cmd_type CMD_READ  = 3'd4;
   localparam cmd_type CMD_ACK   = 3'd5;

   localparam int BITS_PER_BYTE = 8;

   localparam ticks_type HALF_PERIOD_RESET = 16'd250;

endpackage

@@ rtl/i2cmbe_req_if.sv @@
// Command channel carrying one tick of engine input per item.
interface i2cmbe_req_if;
   import i2cmbe_pkg::*;

   logic     valid;
   logic     ready;
   cmd_type  action;
   byte_type tx_byte;
   logic     ack_level;
   logic     sda_in;

   modport source (output valid, action, tx_byte, ack_level, sda_in, input ready);
   modport sink   (input valid, action, tx_byte, ack_level, sda_in, output ready);
endinterface

@@ rtl/i2cmbe_rsp_if.sv @@
// Result channel carrying the pin levels and status for one tick.
interface i2cmbe_rsp_if;
   import i2cmbe_pkg::*;

   logic     valid;
   logic     ready;
   logic     scl_out;
   logic     sda_out;
   logic     sda_drive;
   logic     busy_res;
   logic     done_res;
   byte_type rx_byte;
   logic     ack_seen;

   modport source (output valid, scl_out, sda_out, sda_drive, busy_res, done_res, rx_byte,
                   ack_seen, input ready);
   modport sink   (input valid, scl_out, sda_out, sda_drive, busy_res, done_res, rx_byte,
                   ack_seen, output ready);
endinterface

@@ rtl/i2c_master_bit_engine_top.sv @@
// I2C master bit engine: sequences SCL and SDA for start, stop, byte and acknowledge commands.
// Every request item is one clock tick of the bus engine and yields exactly one response item
// in the cycle after it is accepted; one item is taken per clock cycle, limited only by the
// single response register, which frees as the response item is taken. A command is taken only
// while no command is in progress; each pin step but the last is followed by half_ff idle ticks,
// and done_res pulses on the item in which the last step of a command executes.
module i2c_master_bit_engine_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  i2cmbe_pkg::ticks_type csr_wr_data,
   i2cmbe_req_if.sink            req_bus,
   i2cmbe_rsp_if.source          rsp_bus
);
   import i2cmbe_pkg::*;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_STEP1 = 3'd1;
   localparam logic [2:0] PH_STEP2 = 3'd2;
   localparam logic [2:0] PH_STEP3 = 3'd3;
   localparam logic [2:0] PH_STEP4 = 3'd4;

   localparam logic [3:0] BIT_LIMIT = 4'(BITS_PER_BYTE);

   ticks_type  half_ff;
   cmd_type    cmd_ff,     cmd_in;
   logic [2:0] phase_ff,   phase_in;
   logic [3:0] bit_cnt_ff, bit_cnt_in;
   byte_type   shift_ff,   shift_in;
   ticks_type  delay_ff,   delay_in;
   logic       scl_ff,     scl_in;
   logic       sda_ff,     sda_in;
   logic       ack_ff,     ack_in;
   logic       drive_ff,   drive_in;
   byte_type   rx_hold_ff, rx_hold_in;
   logic       done_ff,    done_in;
   logic       rsp_valid_ff;
   logic       accept;
   logic [3:0] bit_cnt_inc;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign bit_cnt_inc   = bit_cnt_ff + 4'd1;

   always_comb begin
      cmd_in     = cmd_ff;
      phase_in   = phase_ff;
      bit_cnt_in = bit_cnt_ff;
      shift_in   = shift_ff;
      delay_in   = delay_ff;
      scl_in     = scl_ff;
      sda_in     = sda_ff;
      ack_in     = ack_ff;
      drive_in   = drive_ff;
      rx_hold_in = rx_hold_ff;
      done_in    = 1'b0;
      if (cmd_ff == CMD_NONE) begin
         if (req_bus.action inside {[CMD_START:CMD_ACK]}) begin
            cmd_in     = req_bus.action;
            bit_cnt_in = '0;
            drive_in   = 1'b1;
            phase_in   = PH_STEP1;
            delay_in   = half_ff;
            case (req_bus.action)
               CMD_START: begin
                  sda_in = 1'b1;
                  scl_in = 1'b1;
               end
               CMD_STOP: sda_in = 1'b0;
               CMD_ACK:  sda_in = req_bus.ack_level;
               CMD_WRITE: begin
                  shift_in = req_bus.tx_byte;
                  sda_in   = req_bus.tx_byte[7];
               end
               default: begin
                  sda_in   = 1'b1;
                  drive_in = 1'b0;
                  shift_in = '0;
               end
            endcase
         end
      end else if (delay_ff != '0) begin
         delay_in = delay_ff - 16'd1;
      end else begin
         // finish unless a step below advances to a next phase
         cmd_in   = CMD_NONE;
         phase_in = PH_IDLE;
         delay_in = '0;
         done_in  = 1'b1;
         case (cmd_ff)
            CMD_START, CMD_STOP, CMD_ACK: begin
               if (phase_ff == PH_STEP1 || phase_ff == PH_STEP2) begin
                  cmd_in   = cmd_ff;
                  done_in  = 1'b0;
                  delay_in = half_ff;
                  phase_in = (phase_ff == PH_STEP1) ? PH_STEP2 : PH_STEP3;
                  if (cmd_ff == CMD_START) begin
                     if (phase_ff == PH_STEP1) sda_in = 1'b0;
                     else                      scl_in = 1'b0;
                  end else if (cmd_ff == CMD_STOP) begin
                     if (phase_ff == PH_STEP1) scl_in = 1'b1;
                     else                      sda_in = 1'b1;
                  end else begin
                     scl_in = (phase_ff == PH_STEP1);
                  end
               end
            end
            CMD_WRITE: begin
               if (phase_ff == PH_STEP1 || phase_ff == PH_STEP2 || phase_ff == PH_STEP3) begin
                  cmd_in   = cmd_ff;
                  done_in  = 1'b0;
                  delay_in = half_ff;
                  if (phase_ff == PH_STEP2) begin
                     scl_in     = 1'b0;
                     shift_in   = {shift_ff[6:0], 1'b0};
                     bit_cnt_in = bit_cnt_inc;
                     if (bit_cnt_inc < BIT_LIMIT) begin
                        sda_in   = shift_ff[6];
                        phase_in = PH_STEP1;
                     end else begin
                        sda_in   = 1'b1;
                        drive_in = 1'b0;
                        phase_in = PH_STEP3;
                     end
                  end else begin
                     scl_in   = 1'b1;
                     phase_in = (phase_ff == PH_STEP1) ? PH_STEP2 : PH_STEP4;
                  end
               end else begin
                  if (phase_ff == PH_STEP4) ack_in = req_bus.sda_in;
                  scl_in = 1'b0;
               end
            end
            CMD_READ: begin
               if (phase_ff == PH_STEP1 || phase_ff == PH_STEP2) begin
                  cmd_in   = cmd_ff;
                  done_in  = 1'b0;
                  delay_in = half_ff;
                  if (phase_ff == PH_STEP1) begin
                     scl_in   = 1'b1;
                     phase_in = PH_STEP2;
                  end else begin
                     shift_in   = {shift_ff[6:0], req_bus.sda_in};
                     scl_in     = 1'b0;
                     bit_cnt_in = bit_cnt_inc;
                     phase_in   = (bit_cnt_inc < BIT_LIMIT) ? PH_STEP1 : PH_STEP3;
                  end
               end else if (phase_ff == PH_STEP3) begin
                  rx_hold_in = shift_ff;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff      <= HALF_PERIOD_RESET;
         cmd_ff       <= CMD_NONE;
         phase_ff     <= PH_IDLE;
         bit_cnt_ff   <= '0;
         shift_ff     <= '0;
         delay_ff     <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         ack_ff       <= 1'b0;
         drive_ff     <= 1'b1;
         rx_hold_ff   <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            half_ff <= csr_wr_data;
         end
         if (accept) begin
            cmd_ff     <= cmd_in;
            phase_ff   <= phase_in;
            bit_cnt_ff <= bit_cnt_in;
            shift_ff   <= shift_in;
            delay_ff   <= delay_in;
            scl_ff     <= scl_in;
            sda_ff     <= sda_in;
            ack_ff     <= ack_in;
            drive_ff   <= drive_in;
            rx_hold_ff <= rx_hold_in;
            done_ff    <= done_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.scl_out   = scl_ff;
   assign rsp_bus.sda_out   = sda_ff;
   assign rsp_bus.sda_drive = drive_ff;
   assign rsp_bus.busy_res  = (cmd_ff != CMD_NONE);
   assign rsp_bus.done_res  = done_ff;
   assign rsp_bus.rx_byte   = rx_hold_ff;
   assign rsp_bus.ack_seen  = ack_ff;

endmodule

@@ test/i2c_master_bit_engine_top_tb.sv @@
// Self-checking testbench for the I2C master bit engine: directed table, then random ticks.
module i2c_master_bit_engine_top_tb;
   import i2cmbe_pkg::*;

   localparam cmd_type     CMD_SPARE6 = 3'd6;
   localparam cmd_type     CMD_SPARE7 = 3'd7;
   localparam int unsigned MAX_IDLE   = 12;
   localparam int unsigned CYCLE_CAP  = 1_000_000;
   localparam int unsigned RAND_TICKS = 220;

   typedef struct packed {
      cmd_type  action;
      byte_type tx;
      logic     ack_level;
      logic     sda_in;
   } tick_type;

   typedef struct packed {
      logic     scl;
      logic     sda;
      logic     drive;
      logic     busy;
      logic     done;
      byte_type rx;
      logic     ack;
   } pins_type;

   typedef struct {
      tick_type    t;
      int unsigned hold;
      bit          typed;
      pins_type    want;
   } row_type;

   localparam pins_type IDLE_PINS  = '{scl: 1'b1, sda: 1'b1, drive: 1'b1, busy: 1'b0,
                                       done: 1'b0, rx: 8'h00, ack: 1'b0};
   localparam pins_type START_PINS = '{scl: 1'b1, sda: 1'b1, drive: 1'b1, busy: 1'b1,
                                       done: 1'b0, rx: 8'h00, ack: 1'b0};

   logic      clock;
   logic      reset;
   logic      csr_wr_en;
   ticks_type csr_wr_data;

   i2cmbe_req_if req_bus ();
   i2cmbe_rsp_if rsp_bus ();

   i2c_master_bit_engine_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   // engine state as seen by the predictor
   ticks_type   half_ticks = HALF_PERIOD_RESET;
   cmd_type     eng_cmd    = CMD_NONE;
   logic [2:0]  eng_phase  = 3'd0;
   logic [3:0]  eng_bits   = 4'd0;
   byte_type    eng_shift  = 8'h00;
   ticks_type   eng_delay  = 16'd0;
   logic        eng_scl    = 1'b1;
   logic        eng_sda    = 1'b1;
   logic        eng_ack    = 1'b0;
   logic        eng_drive  = 1'b1;
   byte_type    eng_rx     = 8'h00;
   logic        eng_done   = 1'b0;

   pins_type    pins_due[$];
   int unsigned errors     = 0;
   int unsigned cycles     = 0;
   int unsigned stall_left = 0;
   bit          idle_on    = 1'b0;
   pins_type    seen_pins;
   pins_type    want_pins;

   row_type plan [12] = '{
      '{'{CMD_NONE,   8'hFF, 1'b1, 1'b1},  0, 1'b1, IDLE_PINS},
      '{'{CMD_SPARE6, 8'h00, 1'b0, 1'b0},  0, 1'b1, IDLE_PINS},
      '{'{CMD_SPARE7, 8'hFF, 1'b1, 1'b1},  0, 1'b1, IDLE_PINS},
      '{'{CMD_START,  8'h00, 1'b0, 1'b0},  3, 1'b1, START_PINS},
      '{'{CMD_WRITE,  8'hFF, 1'b1, 1'b0},  0, 1'b0, IDLE_PINS},
      '{'{CMD_READ,   8'h00, 1'b0, 1'b1}, 17, 1'b0, IDLE_PINS},
      '{'{CMD_WRITE,  8'h00, 1'b0, 1'b0}, 18, 1'b0, IDLE_PINS},
      '{'{CMD_READ,   8'hFF, 1'b1, 1'b1}, 17, 1'b0, IDLE_PINS},
      '{'{CMD_READ,   8'h80, 1'b0, 1'b0}, 17, 1'b0, IDLE_PINS},
      '{'{CMD_ACK,    8'h01, 1'b0, 1'b1},  3, 1'b0, IDLE_PINS},
      '{'{CMD_ACK,    8'h7F, 1'b1, 1'b0},  3, 1'b0, IDLE_PINS},
      '{'{CMD_STOP,   8'hAA, 1'b1, 1'b1},  3, 1'b0, IDLE_PINS}
   };

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic void await_step(logic [2:0] nxt);
      eng_phase = nxt;
      eng_delay = half_ticks;
   endfunction

   function automatic void finish_cmd();
      eng_cmd   = CMD_NONE;
      eng_phase = 3'd0;
      eng_delay = 16'd0;
      eng_done  = 1'b1;
   endfunction

   function automatic pins_type next_pins(tick_type t);
      pins_type p;
      eng_done = 1'b0;
      if (eng_cmd == CMD_NONE) begin
         if (t.action >= CMD_START && t.action <= CMD_ACK) begin
            eng_cmd   = t.action;
            eng_bits  = 4'd0;
            eng_drive = 1'b1;
            case (t.action)
               CMD_START: begin
                  eng_sda = 1'b1;
                  eng_scl = 1'b1;
               end
               CMD_STOP: eng_sda = 1'b0;
               CMD_ACK:  eng_sda = t.ack_level;
               CMD_WRITE: begin
                  eng_shift = t.tx;
                  eng_sda   = t.tx[7];
               end
               default: begin
                  eng_sda   = 1'b1;
                  eng_drive = 1'b0;
                  eng_shift = 8'h00;
               end
            endcase
            await_step(3'd1);
         end
      end else if (eng_delay != 0) begin
         eng_delay = eng_delay - 16'd1;
      end else begin
         case (eng_cmd)
            CMD_START: begin
               if (eng_phase == 3'd1) begin
                  eng_sda = 1'b0;
                  await_step(3'd2);
               end else if (eng_phase == 3'd2) begin
                  eng_scl = 1'b0;
                  await_step(3'd3);
               end else finish_cmd();
            end
            CMD_STOP: begin
               if (eng_phase == 3'd1) begin
                  eng_scl = 1'b1;
                  await_step(3'd2);
               end else if (eng_phase == 3'd2) begin
                  eng_sda = 1'b1;
                  await_step(3'd3);
               end else finish_cmd();
            end
            CMD_ACK: begin
               if (eng_phase == 3'd1) begin
                  eng_scl = 1'b1;
                  await_step(3'd2);
               end else if (eng_phase == 3'd2) begin
                  eng_scl = 1'b0;
                  await_step(3'd3);
               end else finish_cmd();
            end
            CMD_WRITE: begin
               if (eng_phase == 3'd1) begin
                  eng_scl = 1'b1;
                  await_step(3'd2);
               end else if (eng_phase == 3'd2) begin
                  eng_scl   = 1'b0;
                  eng_shift = {eng_shift[6:0], 1'b0};
                  eng_bits  = eng_bits + 4'd1;
                  if (eng_bits < BITS_PER_BYTE) begin
                     eng_sda = eng_shift[7];
                     await_step(3'd1);
                  end else begin
                     eng_sda   = 1'b1;
                     eng_drive = 1'b0;
                     await_step(3'd3);
                  end
               end else if (eng_phase == 3'd3) begin
                  eng_scl = 1'b1;
                  await_step(3'd4);
               end else begin
                  if (eng_phase == 3'd4) eng_ack = t.sda_in;
                  eng_scl = 1'b0;
                  finish_cmd();
               end
            end
            CMD_READ: begin
               if (eng_phase == 3'd1) begin
                  eng_scl = 1'b1;
                  await_step(3'd2);
               end else if (eng_phase == 3'd2) begin
                  eng_shift = {eng_shift[6:0], t.sda_in};
                  eng_scl   = 1'b0;
                  eng_bits  = eng_bits + 4'd1;
                  await_step((eng_bits < BITS_PER_BYTE) ? 3'd1 : 3'd3);
               end else begin
                  if (eng_phase == 3'd3) eng_rx = eng_shift;
                  finish_cmd();
               end
            end
            default: finish_cmd();
         endcase
      end
      p.scl   = eng_scl;
      p.sda   = eng_sda;
      p.drive = eng_drive;
      p.busy  = (eng_cmd != CMD_NONE);
      p.done  = eng_done;
      p.rx    = eng_rx;
      p.ack   = eng_ack;
      return p;
   endfunction

   function automatic tick_type draw_tick();
      tick_type t;
      if (eng_cmd == CMD_NONE)
         t.action = ($urandom_range(0, 4) != 0) ? cmd_type'($urandom_range(1, 5))
                                                : cmd_type'($urandom_range(0, 7));
      else
         t.action = ($urandom_range(0, 3) != 0) ? CMD_NONE : cmd_type'($urandom_range(0, 7));
      t.tx        = byte_type'($urandom_range(0, 255));
      t.ack_level = 1'($urandom_range(0, 1));
      t.sda_in    = 1'($urandom_range(0, 1));
      return t;
   endfunction

   function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         errors++;
      end
   endfunction

   task automatic push_tick(input tick_type t, input bit typed = 1'b0,
                            input pins_type want = '0);
      int unsigned gap;
      pins_type    p;
      gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.action    <= t.action;
      req_bus.tx_byte   <= t.tx;
      req_bus.ack_level <= t.ack_level;
      req_bus.sda_in    <= t.sda_in;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      p = next_pins(t);
      pins_due.push_back(typed ? want : p);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pins_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_half_period(input ticks_type v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      half_ticks  = v;
   endtask

   // check each result item and pace the result side
   always @(posedge clock) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
         seen_pins = '{rsp_bus.scl_out, rsp_bus.sda_out, rsp_bus.sda_drive, rsp_bus.busy_res,
                       rsp_bus.done_res, rsp_bus.rx_byte, rsp_bus.ack_seen};
         if (pins_due.size() == 0) begin
            $error("result item with no expectation pending");
            errors++;
         end else begin
            want_pins = pins_due.pop_front();
            check_field("scl_out",   8'(want_pins.scl),   8'(seen_pins.scl));
            check_field("sda_out",   8'(want_pins.sda),   8'(seen_pins.sda));
            check_field("sda_drive", 8'(want_pins.drive), 8'(seen_pins.drive));
            check_field("busy_res",  8'(want_pins.busy),  8'(seen_pins.busy));
            check_field("done_res",  8'(want_pins.done),  8'(seen_pins.done));
            check_field("rx_byte",   want_pins.rx,        seen_pins.rx);
            check_field("ack_seen",  8'(want_pins.ack),   8'(seen_pins.ack));
         end
         stall_left = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   initial begin
      while (cycles < CYCLE_CAP) begin
         @(posedge clock);
         cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      ticks_type phase_ticks [6];
      tick_type  t;
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.action    <= CMD_NONE;
      req_bus.tx_byte   <= '0;
      req_bus.ack_level <= 1'b0;
      req_bus.sda_in    <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_half_period(16'd0);
      idle_on = 1'b1;
      foreach (plan[i]) begin
         push_tick(plan[i].t, plan[i].typed, plan[i].want);
         for (int unsigned k = 0; k < plan[i].hold; k++) begin
            t        = plan[i].t;
            t.action = CMD_NONE;
            t.sda_in = plan[i].t.sda_in ^ k[1];
            push_tick(t);
         end
      end

      // run the first wait out and load the second at full length, then shorten the last wait
      settle();
      idle_on = 1'b0;
      set_half_period(16'd24);
      push_tick('{CMD_START, 8'h00, 1'b0, 1'b0});
      repeat (30) push_tick(draw_tick());
      settle();
      set_half_period(16'd2);
      while (eng_cmd != CMD_NONE) push_tick(draw_tick());

      phase_ticks = '{16'd1, 16'd0, 16'd3, 16'd2, ticks_type'($urandom_range(0, 6)), 16'd5};
      foreach (phase_ticks[n]) begin
         settle();
         set_half_period(phase_ticks[n]);
         idle_on = (n % 2 == 0);
         for (int unsigned k = 0; k < RAND_TICKS; k++) begin
            push_tick(draw_tick());
            if ($urandom_range(0, 99) == 0) settle();
         end
      end

      settle();
      repeat (4) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ files.f @@
rtl/i2cmbe_pkg.sv
rtl/i2cmbe_req_if.sv
rtl/i2cmbe_rsp_if.sv
rtl/i2c_master_bit_engine_top.sv
test/i2c_master_bit_engine_top_tb.sv
